[rtl/tilt_mode_hold_to_run_timer_macros.svh]
// assertion macros shared by the checker
`ifndef TILT_MODE_HOLD_TO_RUN_TIMER_MACROS_SVH
`define TILT_MODE_HOLD_TO_RUN_TIMER_MACROS_SVH

// same-cycle implication, off during reset
`define TMHR_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tmhr assertion failed");

// next-cycle implication, off during reset
`define TMHR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tmhr assertion failed");

`endif

[rtl/tmhr_pkg.sv]
`default_nettype none
package tmhr_pkg;

    typedef enum logic [1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_UP      = 2'd1,
        CLS_DOWN    = 2'd2,
        CLS_NONE    = 2'd3
    } cls_t;

    typedef enum logic [0:0] {
        REG_FACE_THRESHOLD = 1'b0,
        REG_STABLE_SAMPLES = 1'b1
    } cfg_reg_t;

    localparam logic [14:0] THRESHOLD_RESET = 15'd13107;
    localparam logic [2:0]  STABLE_RESET    = 3'd5;
    localparam logic [2:0]  RUN_MAX         = 3'd7;

    // floor(x / 1000) = (x * DIV1000_MUL) >> 38 for any 32-bit x
    localparam logic [28:0] DIV1000_MUL = 29'd274877907;
    // floor(x / 60) = (x * DIV60_MUL) >> 37 for any 32-bit x
    localparam logic [31:0] DIV60_MUL   = 32'h8888_8889;

endpackage
`default_nettype wire

[rtl/tilt_mode_hold_to_run_timer.sv]
// tilt mode hold-to-run timer
// input stream s_*: one sensor sample per transfer; tdata carries accel_z,
// button_down and now_ms. output stream m_*: one result per sample with mode,
// flags, elapsed seconds, minutes and seconds.
// cfg_*: register writes (index 0 face threshold, 1 stable sample count),
// always ready; write only while no sample is in flight.
// throughput: one sample per cycle while m_tready is high; five register
// stages (input, state update, divide-by-1000 product, divide-by-60
// product, output), each moves independently, so a bubble is filled as
// soon as it appears. when m_tready is low the output holds and earlier
// stages keep filling until all are full; then s_tready drops.
// reset: all stages empty, tilt state cleared, no mode, timer disarmed,
// threshold 13107 and stable count 5.
`default_nettype none
module tilt_mode_hold_to_run_timer
    import tmhr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // accel_z[15:0], button_down[16],
                                        // now_ms[48:17], zero[55:49]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // focus_mode[1:0], armed[2], held[3],
                                        // elapsed_seconds[26:4], minutes[43:27],
                                        // seconds[49:44], zero[55:50]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);

    logic [14:0] threshold_reg;
    logic [2:0]  stable_reg;

    cls_t        last_class_reg, last_class_next;
    cls_t        accepted_face_reg, accepted_face_next;
    logic [2:0]  stable_run_reg, stable_run_next;
    cls_t        mode_reg, mode_next;
    logic        armed_reg, armed_next;
    logic        held_reg, held_next;
    logic [31:0] session_start_reg, session_start_next;
    logic [31:0] total_ms_reg, total_ms_next;

    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic        rdy0, rdy1, rdy2, rdy3, rdy4;

    logic [15:0] s0_z_reg;
    logic [31:0] s0_now_reg;
    logic        s0_btn_reg;

    logic [1:0]  s1_mode_reg, s2_mode_reg, s3_mode_reg, s4_mode_reg;
    logic        s1_armed_reg, s2_armed_reg, s3_armed_reg, s4_armed_reg;
    logic        s1_held_reg, s2_held_reg, s3_held_reg, s4_held_reg;
    logic [31:0] s1_ms_reg, ms_next;
    logic [60:0] s2_prod_reg;
    logic [22:0] s3_elapsed_reg, s4_elapsed_reg;
    logic [54:0] s3_prod_reg;
    logic [16:0] s4_minutes_reg;
    logic [5:0]  s4_seconds_reg;

    logic        step;
    cls_t        cls;
    logic signed [16:0] z_ext;
    logic signed [16:0] th_ext;
    logic [2:0]  run_inc;
    logic [22:0] elapsed_w;
    logic [16:0] minutes_w;
    logic [22:0] min_times60;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;
    assign step     = v0_reg && rdy1;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            stable_reg    <= STABLE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FACE_THRESHOLD: threshold_reg <= cfg_data;
                REG_STABLE_SAMPLES: stable_reg    <= cfg_data[2:0];
                default:            threshold_reg <= threshold_reg;
            endcase
        end
    end

    // classify and update tilt / timer state
    always_comb
    begin
        z_ext  = signed'({s0_z_reg[15], s0_z_reg});
        th_ext = signed'({2'b00, threshold_reg});
        if (z_ext > th_ext)
            cls = CLS_UP;
        else if (z_ext < -th_ext)
            cls = CLS_DOWN;
        else
            cls = CLS_UNKNOWN;

        run_inc = (stable_run_reg != RUN_MAX) ? stable_run_reg + 3'd1 : RUN_MAX;

        last_class_next    = cls;
        accepted_face_next = accepted_face_reg;
        stable_run_next    = stable_run_reg;
        mode_next          = mode_reg;
        armed_next         = armed_reg;
        held_next          = held_reg;
        session_start_next = session_start_reg;
        total_ms_next      = total_ms_reg;

        if (cls == last_class_reg)
        begin
            stable_run_next = run_inc;
            if (run_inc >= stable_reg)
            begin
                stable_run_next = 3'd0;
                if (accepted_face_reg != cls)
                begin
                    accepted_face_next = cls;
                    if (cls == CLS_UP || cls == CLS_DOWN)
                    begin
                        if (mode_reg != cls)
                        begin
                            mode_next     = cls;
                            total_ms_next = 32'd0;
                            armed_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next     = CLS_UNKNOWN;
                        armed_next    = 1'b0;
                        total_ms_next = 32'd0;
                    end
                end
            end
        end
        else
        begin
            stable_run_next = 3'd1;
        end

        // button edges
        if (s0_btn_reg != held_reg)
        begin
            held_next = s0_btn_reg;
            if (armed_next)
            begin
                if (s0_btn_reg)
                    session_start_next = s0_now_reg;
                else
                    total_ms_next = total_ms_next + (s0_now_reg - session_start_reg);
            end
        end

        ms_next = 32'd0;
        if (mode_next == CLS_UP || mode_next == CLS_DOWN)
        begin
            ms_next = total_ms_next;
            if (held_next && armed_next)
                ms_next = total_ms_next + (s0_now_reg - session_start_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_class_reg    <= CLS_NONE;
            accepted_face_reg <= CLS_NONE;
            stable_run_reg    <= 3'd0;
            mode_reg          <= CLS_UNKNOWN;
            armed_reg         <= 1'b0;
            held_reg          <= 1'b0;
            session_start_reg <= 32'd0;
            total_ms_reg      <= 32'd0;
        end
        else if (step)
        begin
            last_class_reg    <= last_class_next;
            accepted_face_reg <= accepted_face_next;
            stable_run_reg    <= stable_run_next;
            mode_reg          <= mode_next;
            armed_reg         <= armed_next;
            held_reg          <= held_next;
            session_start_reg <= session_start_next;
            total_ms_reg      <= total_ms_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= s_tvalid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    assign elapsed_w   = s2_prod_reg[60:38];
    assign minutes_w   = s3_prod_reg[53:37];
    assign min_times60 = ({6'd0, minutes_w} << 6) - ({6'd0, minutes_w} << 2);

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy0 && s_tvalid)
        begin
            s0_z_reg   <= s_tdata[15:0];
            s0_btn_reg <= s_tdata[16];
            s0_now_reg <= s_tdata[48:17];
        end
        if (rdy1)
        begin
            s1_mode_reg  <= mode_next;
            s1_armed_reg <= armed_next;
            s1_held_reg  <= held_next;
            s1_ms_reg    <= ms_next;
        end
        if (rdy2)
        begin
            s2_mode_reg  <= s1_mode_reg;
            s2_armed_reg <= s1_armed_reg;
            s2_held_reg  <= s1_held_reg;
            s2_prod_reg  <= {29'd0, s1_ms_reg} * {32'd0, DIV1000_MUL};
        end
        if (rdy3)
        begin
            s3_mode_reg    <= s2_mode_reg;
            s3_armed_reg   <= s2_armed_reg;
            s3_held_reg    <= s2_held_reg;
            s3_elapsed_reg <= elapsed_w;
            s3_prod_reg    <= {32'd0, elapsed_w} * {23'd0, DIV60_MUL};
        end
        if (rdy4)
        begin
            s4_mode_reg    <= s3_mode_reg;
            s4_armed_reg   <= s3_armed_reg;
            s4_held_reg    <= s3_held_reg;
            s4_elapsed_reg <= s3_elapsed_reg;
            s4_minutes_reg <= minutes_w;
            s4_seconds_reg <= 6'(s3_elapsed_reg - min_times60);
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {6'd0, s4_seconds_reg, s4_minutes_reg, s4_elapsed_reg,
                       s4_held_reg, s4_armed_reg, s4_mode_reg};

endmodule
`default_nettype wire

[rtl/tmhr_checker.sv]
`default_nettype none
`include "tilt_mode_hold_to_run_timer_macros.svh"
module tmhr_checker
    import tmhr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    logic [1:0]  mode_w;
    logic        armed_w;
    logic [45:0] time_w;
    logic [5:0]  sec_w;
    logic [5:0]  pad_w;
    logic        no_mode;

    assign mode_w  = m_tdata[1:0];
    assign armed_w = m_tdata[2];
    assign time_w  = m_tdata[49:4];
    assign sec_w   = m_tdata[49:44];
    assign pad_w   = m_tdata[55:50];
    assign no_mode = (mode_w == CLS_UNKNOWN);

    `TMHR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TMHR_ASSERT_NOW(a_mode_code, clk, rst_n, m_tvalid, mode_w != CLS_NONE)
    `TMHR_ASSERT_NOW(a_sec_range, clk, rst_n, m_tvalid, sec_w < 6'd60 && pad_w == 6'd0)
    `TMHR_ASSERT_NOW(a_no_mode_idle, clk, rst_n, m_tvalid && no_mode, !armed_w && time_w == '0)

endmodule

bind tilt_mode_hold_to_run_timer tmhr_checker u_tmhr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

[tb/tilt_mode_hold_to_run_timer_tb.sv]
`timescale 1ns / 100ps
module tilt_mode_hold_to_run_timer_tb;
    import tmhr_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd0;

    typedef struct packed {
        logic [1:0]  mode;
        logic        armed;
        logic        held;
        logic [22:0] secs;
        logic [16:0] mins;
        logic [5:0]  sec;
    } timer_report_t;

    typedef struct packed {
        logic signed [15:0] z;
        logic               btn;
        logic [31:0]        now;
        logic               pinned;
        timer_report_t      want;
    } sample_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [14:0] cfg_data = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [55:0] m_tdata;
    wire         cfg_ready;

    tilt_mode_hold_to_run_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predicted tilt state and registers
    logic [1:0]  last_cls_q = CLS_NONE;
    logic [1:0]  face_q = CLS_NONE;
    logic [2:0]  run_q = '0;
    logic [1:0]  mode_q = MODE_NONE;
    logic        armed_q = 1'b0;
    logic        held_q = 1'b0;
    logic [31:0] start_ms_q = '0;
    logic [31:0] total_ms_q = '0;
    logic [14:0] thr_q = THRESHOLD_RESET;
    logic [2:0]  need_q = STABLE_RESET;

    timer_report_t pending_reports[$];
    logic          steady = 1'b0;
    logic          button_lvl = 1'b0;
    logic [31:0]   clock_ms = '0;
    int            sample_count = 0;
    int            result_count = 0;
    int            mismatch_count = 0;
    int            setting_count = 0;
    int            mode_changes = 0;
    logic [22:0]   longest_secs = '0;

    function automatic timer_report_t tilt_step(logic signed [15:0] z, logic btn,
                                                logic [31:0] now);
        cls_t          c;
        int            zi;
        int            ti;
        logic [31:0]   ms;
        logic [31:0]   secs;
        logic [31:0]   mins;
        timer_report_t r;
        zi = z;
        ti = thr_q;
        if (zi > ti)
            c = CLS_UP;
        else if (zi < -ti)
            c = CLS_DOWN;
        else
            c = CLS_UNKNOWN;
        if (c == last_cls_q)
        begin
            if (run_q < RUN_MAX)
                run_q = run_q + 3'd1;
            if (run_q >= need_q)
            begin
                if (face_q != c)
                begin
                    face_q = c;
                    if (c != CLS_UNKNOWN)
                    begin
                        if (mode_q != c)
                        begin
                            mode_q = c;
                            total_ms_q = '0;
                            armed_q = 1'b1;
                            mode_changes++;
                        end
                    end
                    else
                    begin
                        mode_q = MODE_NONE;
                        armed_q = 1'b0;
                        total_ms_q = '0;
                    end
                end
                run_q = '0;
            end
        end
        else
        begin
            run_q = 3'd1;
        end
        last_cls_q = c;
        if (btn != held_q)
        begin
            held_q = btn;
            if (armed_q)
            begin
                if (held_q)
                    start_ms_q = now;
                else
                    total_ms_q = total_ms_q + (now - start_ms_q);
            end
        end
        secs = '0;
        if (mode_q == CLS_UP || mode_q == CLS_DOWN)
        begin
            ms = total_ms_q;
            if (held_q && armed_q)
                ms = total_ms_q + (now - start_ms_q);
            secs = ms / 32'd1000;
        end
        mins = secs / 32'd60;
        r.mode = mode_q;
        r.armed = armed_q;
        r.held = held_q;
        r.secs = secs[22:0];
        r.mins = mins[16:0];
        r.sec = 6'(secs % 32'd60);
        return r;
    endfunction

    // pick a z value that falls in the given class at the current threshold
    function automatic logic [15:0] face_z(cls_t c);
        int t;
        int v;
        logic edge_pick;
        t = thr_q;
        edge_pick = ($urandom_range(7) == 0);
        case (c)
            CLS_UP:
                v = edge_pick ? t + 1 : t + 1 + int'($urandom_range(32766 - t));
            CLS_DOWN:
                v = edge_pick ? -t - 1 : -t - 1 - int'($urandom_range(32767 - t));
            default:
                v = edge_pick ? ($urandom_range(1) ? t : -t) : -t + int'($urandom_range(2 * t));
        endcase
        return v[15:0];
    endfunction

    task automatic report(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic send_sample(input logic [15:0] z, input logic btn, input logic [31:0] now,
                               input logic pinned, input timer_report_t want);
        timer_report_t r;
        while (!steady && $urandom_range(99) < 24)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, now, btn, z};
        do
            @(posedge clk);
        while (!s_tready);
        r = tilt_step(z, btn, now);
        pending_reports.push_back(pinned ? want : r);
        sample_count++;
    endtask

    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [14:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_FACE_THRESHOLD)
            thr_q = val;
        else
            need_q = val[2:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly debounced runs of one face with a button timeline, some noise
    task automatic run_phase(input int count);
        int   sent;
        int   len;
        int   pick;
        cls_t c;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_sample(16'($urandom), 1'($urandom_range(1)), $urandom, 1'b0, '0);
                sent++;
            end
            else
            begin
                pick = $urandom_range(2);
                c = cls_t'(pick);
                if (c == CLS_UP && thr_q == 15'h7fff)
                    c = CLS_UNKNOWN;
                if ($urandom_range(4) == 0)
                    len = $urandom_range((need_q > 1) ? need_q - 1 : 1, 1);
                else
                    len = need_q + $urandom_range(4);
                if (len == 0)
                    len = 1;
                repeat (len)
                begin
                    if ($urandom_range(3) == 0)
                        button_lvl = ~button_lvl;
                    pick = $urandom_range(49);
                    if (pick == 0)
                        clock_ms = $urandom;
                    else if (pick < 3)
                        clock_ms = clock_ms + $urandom_range(300000);
                    else
                        clock_ms = clock_ms + $urandom_range(2500);
                    send_sample(face_z(c), button_lvl, clock_ms, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= 24);

    always @(posedge clk)
    begin : check_results
        timer_report_t got;
        timer_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[1:0], m_tdata[2], m_tdata[3], m_tdata[26:4],
                   m_tdata[43:27], m_tdata[49:44]};
            if (pending_reports.size() == 0)
            begin
                report("result transfer with nothing expected");
            end
            else
            begin
                want = pending_reports.pop_front();
                result_count++;
                if (got.secs > longest_secs)
                    longest_secs = got.secs;
                if (got.mode !== want.mode)
                    report($sformatf("focus_mode %0d, want %0d", got.mode, want.mode));
                if (got.armed !== want.armed)
                    report($sformatf("armed %0d, want %0d", got.armed, want.armed));
                if (got.held !== want.held)
                    report($sformatf("held %0d, want %0d", got.held, want.held));
                if (got.secs !== want.secs)
                    report($sformatf("elapsed_seconds %0d, want %0d", got.secs, want.secs));
                if (got.mins !== want.mins)
                    report($sformatf("minutes %0d, want %0d", got.mins, want.mins));
                if (got.sec !== want.sec)
                    report($sformatf("seconds %0d, want %0d", got.sec, want.sec));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tilt_mode_hold_to_run_timer regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        sample_row_t   dir_rows [22];
        logic [14:0]   thr_set [5];
        logic [2:0]    need_set [5];
        timer_report_t all_zero;
        timer_report_t wrap_hold;
        timer_report_t face_lost;
        all_zero = '0;
        wrap_hold = '{CLS_DOWN, 1'b1, 1'b1, 23'd4294967, 17'd71582, 6'd47};
        face_lost = '{MODE_NONE, 1'b0, 1'b1, 23'd0, 17'd0, 6'd0};
        // face up accepted, hold and release, face down accepted during a hold,
        // session across the timestamp wrap, then unknown clears the mode
        dir_rows = '{
            '{16'sd0,      1'b0, 32'd0,        1'b1, all_zero},
            '{16'sd13108,  1'b0, 32'd100,      1'b0, all_zero},
            '{16'sd13108,  1'b0, 32'd101,      1'b0, all_zero},
            '{16'sd13108,  1'b0, 32'd102,      1'b0, all_zero},
            '{16'sd13108,  1'b0, 32'd103,      1'b0, all_zero},
            '{16'sd13108,  1'b0, 32'd104,      1'b0, all_zero},
            '{16'sd13107,  1'b1, 32'd1000,     1'b0, all_zero},
            '{16'sd32767,  1'b1, 32'd60999,    1'b0, all_zero},
            '{16'sd32767,  1'b0, 32'd62000,    1'b0, all_zero},
            '{16'h8000,    1'b0, 32'd63000,    1'b0, all_zero},
            '{16'h8000,    1'b0, 32'd63001,    1'b0, all_zero},
            '{16'h8000,    1'b1, 32'd0,        1'b0, all_zero},
            '{16'h8000,    1'b1, 32'd1,        1'b0, all_zero},
            '{16'h8000,    1'b1, 32'd2,        1'b0, all_zero},
            '{-16'sd13108, 1'b1, 32'hffffffff, 1'b1, wrap_hold},
            '{-16'sd13108, 1'b0, 32'd5,        1'b0, all_zero},
            '{-16'sd13107, 1'b0, 32'd6,        1'b0, all_zero},
            '{16'sd0,      1'b1, 32'd7,        1'b0, all_zero},
            '{16'sd13107,  1'b1, 32'd8,        1'b0, all_zero},
            '{16'sd1,      1'b1, 32'd9,        1'b0, all_zero},
            '{-16'sd1,     1'b1, 32'd10,       1'b1, face_lost},
            '{16'sd0,      1'b0, 32'd11,       1'b0, all_zero}
        };
        thr_set = '{15'd0, 15'h7fff, 15'($urandom), 15'($urandom_range(20000, 8000)),
                    THRESHOLD_RESET};
        need_set = '{3'd1, 3'd7, 3'd0, 3'($urandom_range(7, 1)), 3'd3};

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 22; i++)
            send_sample(dir_rows[i].z, dir_rows[i].btn, dir_rows[i].now,
                        dir_rows[i].pinned, dir_rows[i].want);
        drain();

        clock_ms = $urandom;
        setting_count = 1;
        run_phase(40);
        drain();
        run_phase(40);

        for (int k = 0; k < 5; k++)
        begin
            drain();
            write_reg(REG_FACE_THRESHOLD, thr_set[k]);
            write_reg(REG_STABLE_SAMPLES, {12'($urandom), need_set[k]});
            setting_count++;
            clock_ms = $urandom;
            steady = (k == 3);
            run_phase(75);
            steady = 1'b0;
        end

        drain();
        repeat (12)
            @(posedge clk);
        $display("covered %0d samples over %0d threshold/debounce settings, %0d results checked",
                 sample_count, setting_count, result_count);
        $display("%0d face changes predicted, longest elapsed time seen %0d s",
                 mode_changes, longest_secs);
        if (mismatch_count == 0)
            $display("tilt_mode_hold_to_run_timer regression: pass");
        else
            $display("tilt_mode_hold_to_run_timer regression: fail");
        $finish;
    end

endmodule
